// ===== design/smvm_pkg.sv =====
// shared types and constants of the sparse matrix-vector multiplier
package smvm_pkg;

  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 10;
  localparam int ROW_W       = 16;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int FRAC_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_NONZERO = 2'd1;
  localparam logic [1:0] REQ_EMPTY   = 2'd2;

  localparam logic signed [ACC_W-1:0]   ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]   ACC_MIN = 48'sh8000_0000_0000;
  localparam logic signed [VALUE_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] OUT_MIN = 32'sh8000_0000;

  // one operation handed from the front to the back
  typedef struct packed {
    logic                      empty_row;
    logic                      last;
    logic signed [VALUE_W-1:0] mat_value;
    logic signed [VALUE_W-1:0] vec_value;
  } op_t;

  // push side of the operation queue
  typedef struct packed {
    logic push;
    op_t  op;
  } push_t;

endpackage

// ===== design/sparse_matrix_vector_multiply.sv =====
// top level of the compressed-row sparse matrix times dense vector unit
//
//  channel  dir  tdata (low bit up)                 tuser        tlast
//  s_axis   in   index[9:0], value[41:10], zeros    req_type     row_end
//  m_axis   out  row_value[31:0], row_number[47:32] saturated    -
//
// one word per cycle in and out while the output is not stalled; the one
// multiply-accumulate per cycle sets that figure
// a row-closing nonzero or empty-row word gives a registered result
// loads write the store in their intake cycle and give no result
// reset clears control, queue and accumulator; the vector store is not cleared
// a stalled output holds the back end; intake goes on until the queue is full
module sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // index, value, zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // row_value, row_number
  output logic        m_axis_tuser    // saturated
);

  import smvm_pkg::*;

  push_t                q_wr;
  op_t                  q_op;
  logic                 q_pop;
  logic                 q_empty;
  logic [QCNT_W-1:0]    q_count;
  logic signed [VALUE_W-1:0] row_value;
  logic [ROW_W-1:0]     row_number;

  smvm_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .req_type (s_axis_tuser),
    .index    (s_axis_tdata[INDEX_W-1:0]),
    .value    ($signed(s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W])),
    .row_end  (s_axis_tlast),
    .q_count  (q_count),
    .q_wr     (q_wr)
  );

  smvm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .pop   (q_pop),
    .rd_op (q_op),
    .empty (q_empty),
    .count (q_count)
  );

  smvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_op       (q_op),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .row_value  (row_value),
    .row_number (row_number),
    .saturated  (m_axis_tuser)
  );

  assign m_axis_tdata = {row_number, row_value};

  // queue never written when full unless a word leaves at the same edge
  assert property (@(posedge clk) disable iff (rst)
    (q_wr.push && !q_pop) |-> (q_count != QCNT_W'(QUEUE_DEPTH)))
    else $error("operation queue overflow");

  // back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("operation queue underflow");

  // intake ready leaves room for the word now being accepted
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("intake ready with a full queue");

endmodule

// ===== design/smvm_ram.sv =====
// generic single-write, single-read ram with registered read data
module smvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/smvm_queue.sv =====
// short operation queue between front and back
module smvm_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  smvm_pkg::push_t                wr,
  input  logic                           pop,
  output smvm_pkg::op_t                  rd_op,
  output logic                           empty,
  output logic [smvm_pkg::QCNT_W-1:0]    count
);

  import smvm_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign rd_op = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/smvm_front.sv =====
// request intake: decode, vector store access and queue push
module smvm_front #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           req_type,
  input  logic [smvm_pkg::INDEX_W-1:0]         index,
  input  logic signed [smvm_pkg::VALUE_W-1:0]  value,
  input  logic                                 row_end,
  input  logic [smvm_pkg::QCNT_W-1:0]          q_count,
  output smvm_pkg::push_t                      q_wr
);

  import smvm_pkg::*;

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic                      accept;
  logic                      is_load;
  logic                      is_nonzero;
  logic                      is_empty;
  logic                      in_range;
  logic [AW-1:0]             addr;
  logic [VALUE_W-1:0]        rd_data;

  // item waiting for its vector element
  logic                      pend_valid;
  logic                      pend_empty;
  logic                      pend_last;
  logic                      pend_in_range;
  logic signed [VALUE_W-1:0] pend_value;

  // keep one slot free for the item in flight
  assign in_ready = (QCNT_W'(q_count) + QCNT_W'(pend_valid)) < QCNT_W'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign in_range = (32'(index) < 32'(VECTOR_DEPTH));
  assign addr     = AW'(index);

  always_comb begin
    is_load    = 1'b0;
    is_nonzero = 1'b0;
    is_empty   = 1'b0;
    unique case (req_type)
      REQ_LOAD:    is_load    = 1'b1;
      REQ_NONZERO: is_nonzero = 1'b1;
      REQ_EMPTY:   is_empty   = 1'b1;
      default:     ;
    endcase
  end

  smvm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_store (
    .clk   (clk),
    .we    (accept && is_load && in_range),
    .waddr (addr),
    .wdata (value),
    .re    (accept && is_nonzero && in_range),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= accept && (is_nonzero || is_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_empty    <= is_empty;
      pend_last     <= row_end;
      pend_in_range <= in_range;
      pend_value    <= value;
    end
  end

  // out-of-range columns multiply by zero
  always_comb begin
    q_wr.push         = pend_valid;
    q_wr.op.empty_row = pend_empty;
    q_wr.op.last      = pend_last;
    q_wr.op.mat_value = pend_value;
    q_wr.op.vec_value = pend_in_range ? $signed(rd_data) : '0;
  end

endmodule

// ===== design/smvm_back.sv =====
// multiply, row accumulation, saturation and result register
module smvm_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  smvm_pkg::op_t                        q_op,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [smvm_pkg::VALUE_W-1:0]  row_value,
  output logic [smvm_pkg::ROW_W-1:0]           row_number,
  output logic                                 saturated
);

  import smvm_pkg::*;

  logic                      go;

  // multiply stage
  logic                      mul_valid;
  logic                      mul_empty;
  logic                      mul_last;
  logic signed [PROD_W-1:0]  mul_prod;

  logic signed [ACC_W-1:0]   acc;
  logic                      acc_clip;
  logic [ROW_W-1:0]          row_count;

  logic signed [ACC_W-1:0]   prod_q;
  logic [ACC_W:0]            sum_wide;
  logic                      sum_ovf;
  logic signed [ACC_W-1:0]   sum_sat;
  logic                      clip_next;
  logic                      fits_out;
  logic signed [VALUE_W-1:0] out_clip;

  assign go    = !out_valid || out_ready;
  assign q_pop = go && !q_empty;

  // q16.16 operands; product floored by a shift of 16 to 16 fraction bits
  assign prod_q    = mul_prod[PROD_W-1:FRAC_W];
  assign sum_wide  = {acc[ACC_W-1], acc} + {prod_q[ACC_W-1], prod_q};
  assign sum_ovf   = sum_wide[ACC_W] != sum_wide[ACC_W-1];
  assign sum_sat   = sum_ovf ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX)
                             : $signed(sum_wide[ACC_W-1:0]);
  assign clip_next = acc_clip || sum_ovf;
  // fits in 32 bits when the upper bits all match the sign
  assign fits_out  = (sum_sat[ACC_W-1:VALUE_W-1] == '0)
                  || (sum_sat[ACC_W-1:VALUE_W-1] == '1);
  assign out_clip  = fits_out ? sum_sat[VALUE_W-1:0]
                              : (sum_sat[ACC_W-1] ? OUT_MIN : OUT_MAX);

  always_ff @(posedge clk) begin
    if (go) begin
      mul_empty <= q_op.empty_row;
      mul_last  <= q_op.last;
      mul_prod  <= q_op.mat_value * q_op.vec_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      acc_clip  <= 1'b0;
      row_count <= '0;
    end else if (go) begin
      mul_valid <= !q_empty;
      out_valid <= mul_valid && (mul_empty || mul_last);
      if (mul_valid) begin
        if (mul_empty || mul_last) begin
          acc       <= '0;
          acc_clip  <= 1'b0;
          row_count <= row_count + 1'b1;
        end else begin
          acc      <= sum_sat;
          acc_clip <= clip_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && mul_valid) begin
      row_number <= row_count;
      if (mul_empty) begin
        row_value <= '0;
        saturated <= 1'b0;
      end else begin
        row_value <= out_clip;
        saturated <= clip_next || !fits_out;
      end
    end
  end

endmodule

// ===== tb/tb_sparse_matrix_vector_multiply.sv =====
// self-checking testbench for the compressed-row sparse matrix times vector unit
`timescale 1ns / 100ps

module tb_sparse_matrix_vector_multiply;
  import smvm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1340;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [VALUE_W-1:0] row_value;
    logic [ROW_W-1:0]   row_number;
    logic               saturated;
  } row_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // index, value, zero pad
  logic [1:0]  s_axis_tuser = '0;   // req_type
  logic        s_axis_tlast = 1'b0; // row_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // row_value, row_number
  logic        m_axis_tuser;        // saturated

  // predictor state
  logic signed [VALUE_W-1:0] vec_mem [1024];
  bit                        vec_loaded [1024];
  int                        loaded_cols [$];
  longint                    row_acc = 0;
  bit                        acc_clip = 1'b0;
  logic [ROW_W-1:0]          row_count = '0;
  row_result_t               rows_due [$];

  bit          idle_on = 1'b1;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          failures = 0;
  int          words_sent = 0;
  int          rows_checked = 0;
  int          sat_rows = 0;
  int          empty_rows = 0;
  int          stall_cycles = 0;
  row_result_t got_row;

  sparse_matrix_vector_multiply dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void finish_row(input row_result_t r);
    r.row_number = row_count;
    rows_due.insert(rows_due.size(), r);
    if (r.saturated) sat_rows++;
    row_count = row_count + 1'b1;
    row_acc = 0;
    acc_clip = 1'b0;
  endfunction

  function automatic void predict_word(input logic [1:0] kind, input logic [9:0] idx,
                                       input logic [31:0] val, input logic last);
    longint      prod;
    longint      sum;
    row_result_t r;
    r = '0;
    case (kind)
      REQ_LOAD: begin
        vec_mem[idx] = val;
        if (!vec_loaded[idx]) begin
          vec_loaded[idx] = 1'b1;
          loaded_cols.insert(loaded_cols.size(), int'(idx));
        end
      end
      REQ_NONZERO: begin
        prod = longint'($signed(val)) * longint'(vec_mem[idx]);
        sum = row_acc + (prod >>> FRAC_W);
        if (sum > longint'(ACC_MAX)) begin
          sum = longint'(ACC_MAX);
          acc_clip = 1'b1;
        end else if (sum < longint'(ACC_MIN)) begin
          sum = longint'(ACC_MIN);
          acc_clip = 1'b1;
        end
        row_acc = sum;
        if (last) begin
          r.saturated = acc_clip;
          if (sum > longint'(OUT_MAX)) begin
            sum = longint'(OUT_MAX);
            r.saturated = 1'b1;
          end else if (sum < longint'(OUT_MIN)) begin
            sum = longint'(OUT_MIN);
            r.saturated = 1'b1;
          end
          r.row_value = sum[31:0];
          finish_row(r);
        end
      end
      REQ_EMPTY: begin
        // drops any partial sum of the row
        empty_rows++;
        finish_row(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    if (pick < 8) return $urandom;
    return extreme_value();
  endfunction

  // columns only from elements already loaded
  function automatic logic [9:0] pick_column();
    return 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [9:0] idx,
                           input logic [31:0] val, input logic last);
    while (idle_on && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {6'b0, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_word(kind, idx, val, last);
    if (kind != REQ_UNUSED) words_sent++;
  endtask

  task automatic send_row(input int nonzeros, input bit harsh, input bit close);
    for (int k = 0; k < nonzeros; k++) begin
      send_word(REQ_NONZERO, pick_column(), harsh ? extreme_value() : rand_value(),
                close && (k == nonzeros - 1));
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(REQ_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b0);
    send_word(REQ_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
    send_word(REQ_LOAD, 10'd1, 32'h0001_0000, 1'b1);   // row end on a load is ignored
    send_word(REQ_LOAD, 10'd2, 32'hFFFE_8000, 1'b0);   // -1.5
    send_word(REQ_NONZERO, 10'd1, 32'h0002_0000, 1'b1);
    // tiny times negative rounds toward minus infinity
    send_word(REQ_NONZERO, 10'd2, 32'h0000_0001, 1'b1);
    send_word(REQ_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    // empty row in the middle of a row
    send_word(REQ_NONZERO, 10'd1, 32'h0005_0000, 1'b0);
    send_word(REQ_EMPTY, 10'd0, 32'h0, 1'b0);
    send_word(REQ_UNUSED, 10'd5, 32'h7FFF_FFFF, 1'b1);
    send_word(REQ_NONZERO, 10'd1023, 32'h8000_0000, 1'b1);
    send_word(REQ_NONZERO, 10'd0, 32'h8000_0000, 1'b1);
    // accumulator clips high, then comes back into the output range
    repeat (3) send_word(REQ_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_word(REQ_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
    send_word(REQ_NONZERO, 10'd0, 32'h8000_0000, 1'b1);
    // accumulator clips low, then a zero value, then back up
    repeat (3) send_word(REQ_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
    send_word(REQ_NONZERO, 10'd1, 32'h0000_0000, 1'b0);
    send_word(REQ_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_word(REQ_NONZERO, 10'd1023, 32'h8000_0000, 1'b1);
    wait_drain();
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    holds_asked++;
    for (int k = 0; k < 24; k++) send_row(1, 1'b0, 1'b1);
    idle_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_stream();
    int start;
    int done;
    int pick;
    start = words_sent;
    repeat (16) send_word(REQ_LOAD, 10'($urandom_range(0, 1023)), rand_value(), 1'b0);
    done = 0;
    while (done < RANDOM_WORDS) begin
      // a stretch with no idling on either side
      idle_on = (done < 500) || (done >= 800);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_row($urandom_range(1, 6), 1'b0, 1'b1);
      end else if (pick < 80) begin
        send_word(REQ_LOAD, 10'($urandom_range(0, 1023)), rand_value(),
                  1'($urandom_range(0, 1)));
      end else if (pick < 86) begin
        send_word(REQ_EMPTY, 10'($urandom_range(0, 1023)), $urandom,
                  1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        // broken row cut off by an empty row
        send_row($urandom_range(1, 3), 1'b0, 1'b0);
        send_word(REQ_EMPTY, 10'($urandom_range(0, 1023)), $urandom, 1'b0);
      end else if (pick < 96) begin
        send_word(REQ_UNUSED, 10'($urandom_range(0, 1023)), $urandom,
                  1'($urandom_range(0, 1)));
      end else begin
        send_row($urandom_range(10, 20), 1'b1, 1'b1);
      end
      done = words_sent - start;
    end
    idle_on = 1'b1;
    wait_drain();
  endtask

  // result side: random stalls, plus a counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 34);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      rows_checked++;
      if (rows_due.size() == 0) begin
        failures++;
        $error("row result with nothing pending: tdata %h tuser %b", m_axis_tdata,
               m_axis_tuser);
      end else begin
        got_row = rows_due.pop_front();
        if (m_axis_tdata[31:0] !== got_row.row_value) begin
          $error("row_value expected %h actual %h", got_row.row_value, m_axis_tdata[31:0]);
          failures++;
        end
        if (m_axis_tdata[47:32] !== got_row.row_number) begin
          $error("row_number expected %0d actual %0d", got_row.row_number,
                 m_axis_tdata[47:32]);
          failures++;
        end
        if (m_axis_tuser !== got_row.saturated) begin
          $error("saturated expected %b actual %b", got_row.saturated, m_axis_tuser);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_sparse_matrix_vector_multiply failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_output_hold();
    test_random_stream();
    $display("sent %0d request words, checked %0d row results (%0d clipped, %0d empty)",
             words_sent, rows_checked, sat_rows, empty_rows);
    $display("covered loads, accumulator and output clipping, broken rows"
             , " and a long output hold-off");
    if (failures == 0 && rows_due.size() == 0) begin
      $display("tb_sparse_matrix_vector_multiply passed");
    end else begin
      $display("tb_sparse_matrix_vector_multiply failed");
    end
    $finish;
  end

endmodule
